@@ hw/rtl/mlr_pkg.sv @@
// shared types, codes and octant tables for the midpoint line rasterizer
`default_nettype none

package mlr_pkg;

  localparam int COORD_BITS = 11;
  localparam int DIFF_BITS  = COORD_BITS + 1;
  localparam int INC_BITS   = COORD_BITS + 2;
  localparam int DEC_BITS   = COORD_BITS + 3;
  localparam int CLIP_BITS  = 12;
  localparam int CFG_INDEX_BITS = 2;

  localparam logic [CFG_INDEX_BITS-1:0] REG_CLIP_WIDTH  = 2'd0;
  localparam logic [CFG_INDEX_BITS-1:0] REG_CLIP_HEIGHT = 2'd1;

  localparam logic [CLIP_BITS-1:0] CLIP_WIDTH_RESET  = 12'd1920;
  localparam logic [CLIP_BITS-1:0] CLIP_HEIGHT_RESET = 12'd1080;

  localparam logic KIND_START = 1'b0;
  localparam logic KIND_STEP  = 1'b1;

  typedef logic [COORD_BITS-1:0]        coord_t;
  typedef logic signed [DIFF_BITS-1:0]  diff_t;
  typedef logic signed [INC_BITS-1:0]   inc_t;
  typedef logic signed [DEC_BITS-1:0]   dec_t;
  typedef logic [CLIP_BITS-1:0]         clip_t;
  typedef logic [2:0]                   mode_t;

  typedef struct packed {
    logic   kind;
    coord_t start_x;
    coord_t start_y;
    coord_t end_x;
    coord_t end_y;
  } in_word_t;

  typedef struct packed {
    coord_t pixel_x;
    coord_t pixel_y;
    logic   drawn;
    logic   last;
  } out_word_t;

  // line parameters produced by the setup logic
  typedef struct packed {
    logic   busy;
    coord_t cur_x;
    coord_t cur_y;
    coord_t major_end;
    dec_t   decision;
    inc_t   step_straight;
    inc_t   step_diagonal;
    mode_t  mode;
  } setup_t;

  typedef struct packed {
    clip_t width;
    clip_t height;
  } clip_win_t;

  // mode is {class, backward}; diagonal taken on d >= 0 when set, d <= 0 when clear
  function automatic logic mode_take_ge(input mode_t mode);
    logic r;
    case (mode)
      3'd0, 3'd2, 3'd5, 3'd7: r = 1'b1;
      default:                r = 1'b0;
    endcase
    return r;
  endfunction

  // minor axis steps up when set, down when clear
  function automatic logic mode_minor_up(input mode_t mode);
    logic r;
    case (mode)
      3'd1, 3'd2, 3'd4, 3'd7: r = 1'b1;
      default:                r = 1'b0;
    endcase
    return r;
  endfunction

endpackage

`default_nettype wire

@@ hw/rtl/midpoint_line_rasterizer.sv @@
// top level of the midpoint line rasterizer with clip window
//
// input channel (in_valid/in_ready/in_data) takes two kinds of word: a start
// word loads both endpoints and sets up the octant, decision and increments
// without producing output; a step word emits the current pixel and moves one
// unit along the major axis. the start point is emitted, the end point is not,
// and the final pixel carries last. step words while no line is active and
// lines with equal endpoints produce nothing.
// output channel (out_valid/out_ready/out_data) carries pixel_x, pixel_y,
// drawn (inside the clip window 1..size-1) and last.
// a step word's pixel is registered into out_data, or into the skid word.
// throughput: one word per cycle; the line state update is one add and
// compare between the state registers, and an output register plus a skid
// word keep in_ready high while one result waits on a stalled receiver.
// when both output words are full in_ready drops until the receiver takes one.
// reset clears the active line, empties the output and loads the clip size
// 1920 x 1080. cfg writes clip width (index 0) or height (index 1) only while
// idle, a rule the user keeps, not the block; other indexes are ignored.
`default_nettype none

module midpoint_line_rasterizer (
  input  logic                                  clk,
  input  logic                                  rst,
  input  logic                                  in_valid,
  output logic                                  in_ready,
  input  mlr_pkg::in_word_t                     in_data,
  output logic                                  out_valid,
  input  logic                                  out_ready,
  output mlr_pkg::out_word_t                    out_data,
  input  logic                                  cfg_write_en,
  input  logic [mlr_pkg::CFG_INDEX_BITS-1:0]    cfg_index,
  input  logic [mlr_pkg::CLIP_BITS-1:0]         cfg_data
);

  mlr_pkg::clip_win_t clip;
  logic               accept;
  logic               push;
  logic               space;
  mlr_pkg::out_word_t result;

  // clip window registers
  always_ff @(posedge clk) begin
    if (rst) begin
      clip.width  <= mlr_pkg::CLIP_WIDTH_RESET;
      clip.height <= mlr_pkg::CLIP_HEIGHT_RESET;
    end else if (cfg_write_en) begin
      if (cfg_index == mlr_pkg::REG_CLIP_WIDTH) begin
        clip.width <= cfg_data;
      end else if (cfg_index == mlr_pkg::REG_CLIP_HEIGHT) begin
        clip.height <= cfg_data;
      end
    end
  end

  // ready only depends on the skid word being free
  assign in_ready = space;
  assign accept   = in_valid && in_ready;

  mlr_core u_core (
    .clk     (clk),
    .rst     (rst),
    .accept  (accept),
    .in_word (in_data),
    .clip    (clip),
    .push    (push),
    .result  (result)
  );

  mlr_out_buf u_out_buf (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_word (result),
    .space     (space),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

endmodule

`default_nettype wire

@@ hw/rtl/mlr_setup.sv @@
// octant classification and decision setup from two endpoints
`default_nettype none

module mlr_setup (
  input  mlr_pkg::in_word_t in_word,
  output mlr_pkg::setup_t   setup
);

  mlr_pkg::diff_t a;
  mlr_pkg::diff_t b;
  mlr_pkg::diff_t a2;
  mlr_pkg::diff_t b2;
  logic signed [mlr_pkg::DIFF_BITS:0]   sum_ab;
  logic signed [mlr_pkg::DEC_BITS-1:0]  twice;
  logic signed [mlr_pkg::DEC_BITS-1:0]  twice_rnd;
  logic a_pos, a_neg, a_zero, b_pos, b_neg, b_zero;
  logic cls0, cls1, cls2;
  logic [1:0] cls;
  logic back;

  assign a = mlr_pkg::diff_t'({1'b0, in_word.end_x}) - mlr_pkg::diff_t'({1'b0, in_word.start_x});
  assign b = mlr_pkg::diff_t'({1'b0, in_word.end_y}) - mlr_pkg::diff_t'({1'b0, in_word.start_y});

  assign a_zero = (a == '0);
  assign b_zero = (b == '0);
  assign a_neg  = a[mlr_pkg::DIFF_BITS-1];
  assign b_neg  = b[mlr_pkg::DIFF_BITS-1];
  assign a_pos  = !a_neg && !a_zero;
  assign b_pos  = !b_neg && !b_zero;

  assign sum_ab = {a[mlr_pkg::DIFF_BITS-1], a} + {b[mlr_pkg::DIFF_BITS-1], b};

  // class tests in priority order
  assign cls0 = (!a_neg && !b_pos && !sum_ab[mlr_pkg::DIFF_BITS]) ||
                (!a_pos && !b_neg && (sum_ab[mlr_pkg::DIFF_BITS] || sum_ab == '0));
  assign cls1 = (a_pos && b_pos && (a >= b)) || (a_neg && b_neg && (a <= b));
  assign cls2 = (!b_neg && !a_neg && (a < b)) || (!b_pos && !a_pos && (a > b));

  always_comb begin
    if (cls0) begin
      cls = 2'd0;
      a2  = a;
      b2  = -b;
    end else if (cls1) begin
      cls = 2'd1;
      a2  = a;
      b2  = b;
    end else if (cls2) begin
      cls = 2'd2;
      a2  = -b;
      b2  = -a;
    end else begin
      cls = 2'd3;
      a2  = -b;
      b2  = a;
    end
  end

  assign back = cls[1] ? !b_pos : !a_pos;

  // (2*b2 - a2) / 2 rounded toward zero
  assign twice     = {b2[mlr_pkg::DIFF_BITS-1], b2, 1'b0} -
                     {{2{a2[mlr_pkg::DIFF_BITS-1]}}, a2};
  assign twice_rnd = twice + {{(mlr_pkg::DEC_BITS-1){1'b0}}, twice[mlr_pkg::DEC_BITS-1]};

  always_comb begin
    setup.busy          = !(a_zero && b_zero);
    setup.cur_x         = in_word.start_x;
    setup.cur_y         = in_word.start_y;
    setup.major_end     = cls[1] ? in_word.end_y : in_word.end_x;
    setup.decision      = twice_rnd >>> 1;
    setup.step_diagonal = {b2[mlr_pkg::DIFF_BITS-1], b2} - {a2[mlr_pkg::DIFF_BITS-1], a2};
    setup.step_straight = {b2[mlr_pkg::DIFF_BITS-1], b2};
    setup.mode          = {cls, back};
  end

endmodule

`default_nettype wire

@@ hw/rtl/mlr_core.sv @@
// line state registers and the per-pixel midpoint step
`default_nettype none

module mlr_core (
  input  logic                clk,
  input  logic                rst,
  input  logic                accept,
  input  mlr_pkg::in_word_t   in_word,
  input  mlr_pkg::clip_win_t  clip,
  output logic                push,
  output mlr_pkg::out_word_t  result
);

  mlr_pkg::setup_t  setup;
  logic             busy;
  mlr_pkg::coord_t  cur_x;
  mlr_pkg::coord_t  cur_y;
  mlr_pkg::coord_t  major_end;
  mlr_pkg::dec_t    decision;
  mlr_pkg::inc_t    step_straight;
  mlr_pkg::inc_t    step_diagonal;
  mlr_pkg::mode_t   mode;

  mlr_pkg::coord_t  cur_x_next;
  mlr_pkg::coord_t  cur_y_next;
  mlr_pkg::dec_t    decision_next;
  mlr_pkg::coord_t  minor_cur;
  mlr_pkg::coord_t  minor_step;
  mlr_pkg::coord_t  major_cur;
  mlr_pkg::coord_t  major_step;
  logic             major_y;
  logic             drawn;
  logic             take;
  logic             dec_neg;
  logic             dec_zero;
  logic             last;
  logic             is_start;

  mlr_setup u_setup (
    .in_word (in_word),
    .setup   (setup)
  );

  assign is_start = (in_word.kind == mlr_pkg::KIND_START);
  assign push     = accept && !is_start && busy;

  assign major_y = mode[2];
  assign drawn   = (cur_x != '0) && ({1'b0, cur_x} < clip.width) &&
                   (cur_y != '0) && ({1'b0, cur_y} < clip.height);

  assign dec_neg  = decision[mlr_pkg::DEC_BITS-1];
  assign dec_zero = (decision == '0);
  assign take     = mlr_pkg::mode_take_ge(mode) ? !dec_neg : (dec_neg || dec_zero);

  assign minor_cur  = major_y ? cur_x : cur_y;
  assign minor_step = mlr_pkg::mode_minor_up(mode) ? minor_cur + 1'b1 : minor_cur - 1'b1;
  assign major_cur  = major_y ? cur_y : cur_x;
  assign major_step = mode[0] ? major_cur - 1'b1 : major_cur + 1'b1;
  assign last       = (major_step == major_end);

  always_comb begin
    decision_next = decision;
    cur_x_next    = cur_x;
    cur_y_next    = cur_y;
    if (drawn) begin
      if (take) begin
        decision_next = decision + {step_diagonal[mlr_pkg::INC_BITS-1], step_diagonal};
        if (major_y) begin
          cur_x_next = minor_step;
        end else begin
          cur_y_next = minor_step;
        end
      end else begin
        decision_next = decision + {step_straight[mlr_pkg::INC_BITS-1], step_straight};
      end
    end
    if (major_y) begin
      cur_y_next = major_step;
    end else begin
      cur_x_next = major_step;
    end
  end

  always_comb begin
    result.pixel_x = cur_x;
    result.pixel_y = cur_y;
    result.drawn   = drawn;
    result.last    = last;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
    end else if (accept) begin
      if (is_start) begin
        busy <= setup.busy;
      end else if (busy && last) begin
        busy <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      if (is_start) begin
        cur_x         <= setup.cur_x;
        cur_y         <= setup.cur_y;
        major_end     <= setup.major_end;
        decision      <= setup.decision;
        step_straight <= setup.step_straight;
        step_diagonal <= setup.step_diagonal;
        mode          <= setup.mode;
      end else if (busy) begin
        cur_x    <= cur_x_next;
        cur_y    <= cur_y_next;
        decision <= decision_next;
      end
    end
  end

endmodule

`default_nettype wire

@@ hw/rtl/mlr_out_buf.sv @@
// output register with a skid stage
`default_nettype none

module mlr_out_buf (
  input  logic               clk,
  input  logic               rst,
  input  logic               push,
  input  mlr_pkg::out_word_t push_word,
  output logic               space,
  output logic               out_valid,
  input  logic               out_ready,
  output mlr_pkg::out_word_t out_data
);

  logic               skid_valid;
  mlr_pkg::out_word_t skid_word;
  logic               pop;

  assign space = !skid_valid;
  assign pop   = out_valid && out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      skid_valid <= 1'b0;
    end else if (skid_valid) begin
      if (pop) begin
        skid_valid <= 1'b0;
      end
    end else if (push) begin
      if (out_valid && !out_ready) begin
        skid_valid <= 1'b1;
      end else begin
        out_valid <= 1'b1;
      end
    end else if (pop) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (skid_valid) begin
      if (pop) begin
        out_data <= skid_word;
      end
    end else if (push) begin
      if (out_valid && !out_ready) begin
        skid_word <= push_word;
      end else begin
        out_data <= push_word;
      end
    end
  end

endmodule

`default_nettype wire
